>>> rtl/dqsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqsc_pkg : shared types and constants of the dual quadrature speed counter
// Beat layouts of both channels, register indexes, per-motor interfaces.
// ---------------------------------------------------------------------------
package dqsc_pkg;

  localparam int SPEED_W         = 16;
  localparam int TOTAL_OUT_W     = 32;
  localparam int WINDOW_BITS_DEF = 16;
  localparam int TOTAL_BITS_DEF  = 32;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_UP_LEVEL  = 1'b0,
    CFG_RIGHT_UP_LEVEL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic left_phase_a;
    logic left_phase_b;
    logic right_phase_a;
    logic right_phase_b;
    logic period_tick;
  } in_beat_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0]     left_speed;
    logic signed [SPEED_W-1:0]     right_speed;
    logic                          left_reverse;
    logic                          right_reverse;
    logic signed [TOTAL_OUT_W-1:0] left_total;
    logic signed [TOTAL_OUT_W-1:0] right_total;
  } out_beat_t;

  // One motor's view of a sample
  typedef struct packed {
    logic step;
    logic phase_a;
    logic phase_b;
    logic up_level;
    logic tick;
  } motor_in_t;

  // One motor's snapshot, valid when the sample carries a tick
  typedef struct packed {
    logic signed [SPEED_W-1:0]     speed;
    logic                          reverse;
    logic signed [TOTAL_OUT_W-1:0] total;
  } motor_res_t;

endpackage

>>> rtl/dqsc_motor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqsc_motor : edge decoder, window counter and running total of one motor
// Counts 2x quadrature edges into a saturating window, folds the window into
// a wrapping total on a tick and presents the snapshot.
// ---------------------------------------------------------------------------
module dqsc_motor #(
  parameter int WINDOW_BITS = dqsc_pkg::WINDOW_BITS_DEF,
  parameter int TOTAL_BITS  = dqsc_pkg::TOTAL_BITS_DEF,
  parameter bit A_PRIORITY  = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dqsc_pkg::motor_in_t  ctl,
  output dqsc_pkg::motor_res_t res
);
  import dqsc_pkg::*;

  logic                          prev_a_r, prev_b_r;
  logic signed [WINDOW_BITS-1:0] window_r, window_nxt;
  logic        [TOTAL_BITS-1:0]  sum_r, sum_nxt;

  logic                          a_edge, b_edge;
  logic signed [2:0]             d_a, d_b, delta;
  logic signed [WINDOW_BITS:0]   win_wide;
  logic signed [WINDOW_BITS-1:0] win_sat;
  logic        [TOTAL_BITS-1:0]  win_ext;

  assign a_edge = ctl.phase_a & ~prev_a_r;
  assign b_edge = ctl.phase_b & ~prev_b_r;
  assign d_a    = (ctl.phase_b == ctl.up_level) ? 3'sd1 : -3'sd1;
  assign d_b    = (ctl.phase_a == ctl.up_level) ? -3'sd1 : 3'sd1;

  always_comb begin
    delta = 3'sd0;
    if (A_PRIORITY) begin
      priority if (a_edge) delta = d_a;
      else if (b_edge)     delta = d_b;
      else                 delta = 3'sd0;
    end else begin
      delta = (a_edge ? d_a : 3'sd0) + (b_edge ? d_b : 3'sd0);
    end
  end

  // Clamp on overflow: the top two bits of the widened sum disagree
  assign win_wide = {window_r[WINDOW_BITS-1], window_r}
                  + {{(WINDOW_BITS-2){delta[2]}}, delta};

  always_comb begin
    if (win_wide[WINDOW_BITS] != win_wide[WINDOW_BITS-1]) begin
      win_sat = win_wide[WINDOW_BITS] ? {1'b1, {(WINDOW_BITS-1){1'b0}}}
                                      : {1'b0, {(WINDOW_BITS-1){1'b1}}};
    end else begin
      win_sat = win_wide[WINDOW_BITS-1:0];
    end
  end

  generate
    if (WINDOW_BITS >= TOTAL_BITS) begin : g_ext_trunc
      assign win_ext = win_sat[TOTAL_BITS-1:0];
    end else begin : g_ext_sign
      assign win_ext = {{(TOTAL_BITS-WINDOW_BITS){win_sat[WINDOW_BITS-1]}}, win_sat};
    end
  endgenerate

  always_comb begin
    window_nxt = window_r;
    sum_nxt    = sum_r;
    if (ctl.step) begin
      if (ctl.tick) begin
        sum_nxt    = sum_r + win_ext;
        window_nxt = '0;
      end else begin
        window_nxt = win_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      prev_b_r <= 1'b0;
      window_r <= '0;
      sum_r    <= '0;
    end else begin
      if (ctl.step) begin
        prev_a_r <= ctl.phase_a;
        prev_b_r <= ctl.phase_b;
      end
      window_r <= window_nxt;
      sum_r    <= sum_nxt;
    end
  end

  // Speed field: clamp or sign-extend the window to the fixed speed width
  generate
    if (WINDOW_BITS > SPEED_W) begin : g_spd_clamp
      logic fits;
      assign fits = (&win_sat[WINDOW_BITS-1:SPEED_W-1])
                  | ~(|win_sat[WINDOW_BITS-1:SPEED_W-1]);
      assign res.speed = fits ? win_sat[SPEED_W-1:0]
                       : (win_sat[WINDOW_BITS-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                                 : {1'b0, {(SPEED_W-1){1'b1}}});
    end else if (WINDOW_BITS == SPEED_W) begin : g_spd_same
      assign res.speed = win_sat;
    end else begin : g_spd_ext
      assign res.speed = {{(SPEED_W-WINDOW_BITS){win_sat[WINDOW_BITS-1]}}, win_sat};
    end
  endgenerate

  generate
    if (TOTAL_BITS >= TOTAL_OUT_W) begin : g_tot_trunc
      assign res.total = sum_nxt[TOTAL_OUT_W-1:0];
    end else begin : g_tot_ext
      assign res.total = {{(TOTAL_OUT_W-TOTAL_BITS){sum_nxt[TOTAL_BITS-1]}}, sum_nxt};
    end
  endgenerate

  assign res.reverse = win_sat[WINDOW_BITS-1];

endmodule

>>> rtl/dual_quadrature_speed_counter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_quadrature_speed_counter_core : two-motor 2x quadrature speed counter
// Edge counting per sample beat, snapshot of window counts and totals on tick.
// ---------------------------------------------------------------------------
// Each input beat is one sample of both encoders' phases plus a period tick.
// The block takes one beat every clock while in_stall is low: a beat is
// captured in an input register, its edges are counted as it advances out
// of that register, and a tick beat then leaves its snapshot in the output
// register, where it is offered until taken. Beats without a tick never
// produce a result.
// in_stall rises only when a tick beat sits in the input register while an
// earlier snapshot is still held by out_stall; the output register is the one
// slot that decides this. Write the up-level registers only while idle; only
// bit 0 of the write data is used.
module dual_quadrature_speed_counter_core #(
  parameter int WINDOW_BITS = dqsc_pkg::WINDOW_BITS_DEF,
  parameter int TOTAL_BITS  = dqsc_pkg::TOTAL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dqsc_pkg::in_beat_t                  in_beat,
  // snapshot beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output dqsc_pkg::out_beat_t                 out_beat,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [dqsc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dqsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dqsc_pkg::*;

  // up-level registers
  logic      left_up_r, right_up_r;

  // input stage
  logic      in_vld_r, in_vld_nxt;
  in_beat_t  in_r;

  // output stage
  logic      out_vld_r, out_vld_nxt;
  out_beat_t out_r;

  logic       advance, take_in;
  motor_in_t  left_in, right_in;
  motor_res_t left_res, right_res;

  // Configuration: decode the index, keep bit 0 of the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_up_r  <= 1'b0;
      right_up_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_LEFT_UP_LEVEL:  left_up_r  <= cfg_wdata[0];
        CFG_RIGHT_UP_LEVEL: right_up_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance the held sample unless it carries a tick and the output slot is
  // still occupied by a stalled snapshot.
  assign advance  = in_vld_r & (~in_r.period_tick | ~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;
  assign take_in  = in_valid & ~in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take_in)      in_vld_nxt = 1'b1;
    else if (advance) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_vld_nxt;
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (take_in) in_r <= in_beat;
  end

  // Counting units: the left motor lets an A edge drop a simultaneous B edge
  assign left_in  = '{step: advance, phase_a: in_r.left_phase_a,
                      phase_b: in_r.left_phase_b, up_level: left_up_r,
                      tick: in_r.period_tick};
  assign right_in = '{step: advance, phase_a: in_r.right_phase_a,
                      phase_b: in_r.right_phase_b, up_level: right_up_r,
                      tick: in_r.period_tick};

  dqsc_motor #(
    .WINDOW_BITS (WINDOW_BITS),
    .TOTAL_BITS  (TOTAL_BITS),
    .A_PRIORITY  (1'b1)
  ) u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (left_in),
    .res   (left_res)
  );

  dqsc_motor #(
    .WINDOW_BITS (WINDOW_BITS),
    .TOTAL_BITS  (TOTAL_BITS),
    .A_PRIORITY  (1'b0)
  ) u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (right_in),
    .res   (right_res)
  );

  // Output slot: load on a tick sample, drop once the beat is taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && in_r.period_tick) out_vld_nxt = 1'b1;
    else if (!out_stall)             out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= out_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (advance && in_r.period_tick) begin
      out_r.left_speed    <= left_res.speed;
      out_r.right_speed   <= right_res.speed;
      out_r.left_reverse  <= left_res.reverse;
      out_r.right_reverse <= right_res.reverse;
      out_r.left_total    <= left_res.total;
      out_r.right_total   <= right_res.total;
    end
  end

  assign out_valid = out_vld_r;
  assign out_beat  = out_r;

endmodule

>>> rtl/dqsc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqsc_checker : port-level checks of the dual quadrature speed counter
// Watches the handshakes and snapshot fields of the top level over time.
// ---------------------------------------------------------------------------
module dqsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dqsc_pkg::out_beat_t out_beat
);
  import dqsc_pkg::*;

  // a stalled snapshot holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("snapshot changed or dropped while stalled");

  // reset empties both stages
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("stage still occupied after reset");

  // input back-pressure only comes from a held snapshot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output slot free");

  // direction flags follow the sign of the clamped speed
  a_reverse_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.left_reverse == out_beat.left_speed[SPEED_W-1]) &&
                  (out_beat.right_reverse == out_beat.right_speed[SPEED_W-1]))
    else $error("reverse flag disagrees with speed sign");

endmodule

bind dual_quadrature_speed_counter_core dqsc_checker u_dqsc_checker (.*);
